// ----- rtl/lru_page_replacement_macros.svh -----
// Assertion macros for the port-level checker of the LRU frame table.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrupr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrupr assertion failed");

`endif

// ----- rtl/lrupr_pkg.sv -----
// Package for the LRU frame table: constants, controller states and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package lrupr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CFG_W         = 5;
  localparam int FRAME_IDX_W   = 4;
  localparam int FAULT_W       = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_e;

  typedef struct packed {
    logic capture;
    logic look;
    logic scan;
    logic update;
  } lrupr_cmd_t;

  typedef struct packed {
    logic resolved;
    logic scan_done;
  } lrupr_status_t;

endpackage

`default_nettype wire

// ----- rtl/lrupr_ctrl.sv -----
// Controller state machine of the LRU frame table.
// Depends on lrupr_pkg; drives the datapath through lrupr_cmd_t.
`default_nettype none

module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire lrupr_status_t status_i,
  output lrupr_cmd_t         cmd_o,
  output logic               busy_o
);

  lrupr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = status_i.resolved ? ST_UPDATE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_LOOK:   cmd_o.look   = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lrupr_dp.sv -----
// Datapath of the LRU frame table: frame tags, valid bits, recency ranks,
// fault counter and the frames_in_use register. Depends on lrupr_pkg.
`default_nettype none

module lrupr_dp
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lrupr_cmd_t             cmd_i,
  output lrupr_status_t               status_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic [PAGE_BITS-1:0]   page_number_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [FRAME_IDX_W-1:0]      frame_index_o,
  output logic                        filled_empty_o,
  output logic [FAULT_W-1:0]          fault_total_o
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

  logic [CFG_W-1:0]     frames_in_use_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] pages_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [IW-1:0]        rank_q  [FRAMES];
  logic [FAULT_W-1:0]   fault_q;
  logic                 hit_q, filled_q, nolimit_q, done_q;
  logic [IW-1:0]        frame_q;
  logic [IW-1:0]        limit_q;
  logic [CW-1:0]        scan_q;

  logic [6:0]           cfg_ext, n_ext;
  logic [CW-1:0]        n_eff;
  logic [FRAMES-1:0]    act, match, empty;
  logic                 any_match, any_empty, seen_m, seen_e;
  logic [IW-1:0]        m_idx, e_idx, m_rank, scan_rank;
  logic                 scan_done;

  always_comb begin
    cfg_ext = 7'(frames_in_use_q);
    if (cfg_ext == 7'd0) begin
      n_ext = 7'd1;
    end else if (cfg_ext > 7'(FRAMES)) begin
      n_ext = 7'(FRAMES);
    end else begin
      n_ext = cfg_ext;
    end
    n_eff = CW'(n_ext);
  end

  always_comb begin
    match     = '0;
    empty     = '0;
    seen_m    = 1'b0;
    seen_e    = 1'b0;
    m_idx     = '0;
    e_idx     = '0;
    m_rank    = '0;
    for (int i = 0; i < FRAMES; i++) begin
      act[i]   = (CW'(i) < n_eff);
      match[i] = act[i] & valid_q[i] & (pages_q[i] == page_q);
      empty[i] = act[i] & ~valid_q[i];
      if (match[i] && !seen_m) begin
        m_idx  = IW'(i);
        m_rank = rank_q[i];
      end
      if (empty[i] && !seen_e) begin
        e_idx = IW'(i);
      end
      seen_m = seen_m | match[i];
      seen_e = seen_e | empty[i];
    end
    any_match = seen_m;
    any_empty = seen_e;
  end

  assign scan_done          = (scan_q >= n_eff);
  assign scan_rank          = rank_q[scan_q[IW-1:0]];
  assign status_o.resolved  = any_match | any_empty;
  assign status_o.scan_done = scan_done;

  // Control state: configuration, valid bits, ranks, fault count, scan count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RST;
      valid_q         <= '0;
      fault_q         <= '0;
      done_q          <= 1'b0;
      scan_q          <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      done_q <= cmd_i.update;
      if (cfg_we_i) begin
        frames_in_use_q <= cfg_wdata_i;
      end
      if (cmd_i.look) begin
        scan_q <= CW'(1);
      end else if (cmd_i.scan && !scan_done) begin
        scan_q <= scan_q + CW'(1);
      end
      if (cmd_i.update) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (IW'(i) == frame_q) begin
            rank_q[i] <= '0;
          end else if (act[i] && valid_q[i] && (nolimit_q || rank_q[i] < limit_q) &&
                       rank_q[i] < RANK_MAX) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end
        if (!hit_q) begin
          valid_q[frame_q] <= 1'b1;
          if (fault_q != '1) begin
            fault_q <= fault_q + FAULT_W'(1);
          end
        end
      end
    end
  end

  // Payload: the referenced page, frame tags and the working result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_number_i;
    end
    if (cmd_i.look) begin
      hit_q     <= any_match;
      filled_q  <= ~any_match & any_empty;
      nolimit_q <= ~any_match & any_empty;
      frame_q   <= any_match ? m_idx : (any_empty ? e_idx : '0);
      limit_q   <= any_match ? m_rank : rank_q[0];
    end else if (cmd_i.scan && !scan_done) begin
      if (scan_rank > limit_q) begin
        limit_q <= scan_rank;
        frame_q <= scan_q[IW-1:0];
      end
    end
    if (cmd_i.update && !hit_q) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IW'(i) == frame_q) begin
          pages_q[i] <= page_q;
        end
      end
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign filled_empty_o = filled_q;
  assign frame_index_o  = FRAME_IDX_W'(frame_q);
  assign fault_total_o  = fault_q;

endmodule

`default_nettype wire

// ----- rtl/lru_page_replacement.sv -----
// Top level of the LRU frame table: controller plus datapath.
// Depends on lrupr_pkg, lrupr_ctrl and lrupr_dp.
//
// Each item is one page reference, given on page_number_i and taken at a
// rising edge with start_i high and busy_o low. The result appears on hit_o,
// frame_index_o, filled_empty_o and fault_total_o, marked by done_o high for
// exactly one cycle; the receiver cannot stall, and the outputs hold the
// result only until the next item updates them. A hit or a fill of an empty
// frame goes from the look step to the update step; a replacement passes
// through a scan step between them, where the least recently used frame is
// found by a scan that reads one recency rank per cycle. done_o follows the
// update step; a new item may be started in the cycle that done_o is high.
// The user must write frames_in_use through cfg_we_i and cfg_wdata_i only
// while idle; the block itself does not enforce this. 0 acts as 1 and values
// above FRAMES act as FRAMES. Reset empties every frame, clears ranks and
// the fault count, and sets frames_in_use to 16: no clearing pass is needed.
`default_nettype none

module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [PAGE_BITS-1:0]   page_number_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [FRAME_IDX_W-1:0]      frame_index_o,
  output logic                        filled_empty_o,
  output logic [FAULT_W-1:0]          fault_total_o
);

  lrupr_cmd_t    cmd;
  lrupr_status_t status;

  lrupr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .page_number_i  (page_number_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .filled_empty_o (filled_empty_o),
    .fault_total_o  (fault_total_o)
  );

endmodule

`default_nettype wire

// ----- rtl/lru_page_replacement_chk.sv -----
// Port-level checker for the LRU frame table, bound to the top level.
// Depends on lrupr_pkg and lru_page_replacement_macros.svh.
`default_nettype none
`include "lru_page_replacement_macros.svh"

module lru_page_replacement_chk
  import lrupr_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start_i,
  input wire logic                   busy_o,
  input wire logic                   done_o,
  input wire logic                   hit_o,
  input wire logic                   filled_empty_o,
  input wire logic [FAULT_W-1:0]     fault_total_o
);

  `LRUPR_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)
  `LRUPR_ASSERT_IMP(a_done_idle, done_o, !busy_o && $past(busy_o))
  `LRUPR_ASSERT_IMP(a_fill_is_fault, done_o && filled_empty_o, !hit_o)
  `LRUPR_ASSERT_IMP(a_fault_counted, done_o && !hit_o, fault_total_o != '0)

endmodule

bind lru_page_replacement lru_page_replacement_chk u_chk (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the LRU frame table (lru_page_replacement).
// Depends on lrupr_pkg and the RTL; predicts every result and checks it.
`default_nettype none

module testbench;
  import lrupr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ACT_PAGE,
    ACT_CFG,
    ACT_DRAIN
  } action_e;

  typedef struct {
    action_e                  act;
    logic [PAGE_BITS_DEF-1:0] page;
    logic [CFG_W-1:0]         cfg;
    int                       gap;
  } access_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   filled_empty;
    logic [FAULT_W-1:0]     fault_total;
  } frame_outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [PAGE_BITS_DEF-1:0] page_number_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata_i = FRAMES_IN_USE_RST;
  logic                     busy_o;
  logic                     done_o;
  logic                     hit_o;
  logic [FRAME_IDX_W-1:0]   frame_index_o;
  logic                     filled_empty_o;
  logic [FAULT_W-1:0]       fault_total_o;

  lru_page_replacement u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .filled_empty_o (filled_empty_o),
    .fault_total_o  (fault_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  access_t        access_q[$];
  frame_outcome_t outcome_q[$];
  int             n_accepted;
  int             n_results;
  int             n_errors;

  // Predicted state of the frame table.
  logic [PAGE_BITS_DEF-1:0] fr_page[FRAMES_DEF];
  logic                     fr_valid[FRAMES_DEF];
  int unsigned              fr_rank[FRAMES_DEF];
  logic [FAULT_W-1:0]       fault_count;
  logic [CFG_W-1:0]         frames_cfg;

  function automatic int eff_frames(input logic [CFG_W-1:0] cfg);
    if (cfg < 1) return 1;
    if (cfg > FRAMES_DEF) return FRAMES_DEF;
    return int'(cfg);
  endfunction

  function automatic frame_outcome_t reference_page(input logic [PAGE_BITS_DEF-1:0] page);
    frame_outcome_t res;
    int             n;
    int             f;
    int unsigned    limit;
    logic           found;
    res = '0;
    n = eff_frames(frames_cfg);
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && fr_valid[i] && fr_page[i] == page) begin
        found = 1'b1;
        f = i;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      limit = fr_rank[f];
    end else begin
      if (fault_count != '1) fault_count = fault_count + 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!res.filled_empty && !fr_valid[i]) begin
          res.filled_empty = 1'b1;
          f = i;
        end
      end
      if (res.filled_empty) begin
        fr_valid[f] = 1'b1;
        limit = FRAMES_DEF;
      end else begin
        f = 0;
        for (int i = 1; i < n; i++) begin
          if (fr_rank[i] > fr_rank[f]) f = i;
        end
        limit = fr_rank[f];
      end
      fr_page[f] = page;
    end
    for (int i = 0; i < n; i++) begin
      if (i != f && fr_valid[i] && fr_rank[i] < limit && fr_rank[i] < FRAMES_DEF - 1)
        fr_rank[i]++;
    end
    fr_rank[f] = 0;
    res.frame = FRAME_IDX_W'(f);
    res.fault_total = fault_count;
    return res;
  endfunction

  // Driver: starts items from the access queue and applies register writes when idle.
  logic                     nxt_start;
  logic                     nxt_we;
  logic [PAGE_BITS_DEF-1:0] nxt_page;
  logic [CFG_W-1:0]         nxt_wdata;
  logic                     idle_now;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      page_number_i <= '0;
      cfg_we_i <= 1'b0;
      cfg_wdata_i <= FRAMES_IN_USE_RST;
    end else begin
      nxt_start = start_i;
      nxt_we = 1'b0;
      nxt_page = page_number_i;
      nxt_wdata = cfg_wdata_i;
      if (start_i && !busy_o) begin
        outcome_q.push_back(reference_page(page_number_i));
        n_accepted++;
      end
      idle_now = (n_accepted == n_results) && !busy_o && !done_o;
      if (!(start_i && busy_o)) begin
        nxt_start = 1'b0;
        if (access_q.size() != 0) begin
          case (access_q[0].act)
            ACT_PAGE: begin
              if (access_q[0].gap > 0) begin
                access_q[0].gap--;
              end else begin
                nxt_start = 1'b1;
                nxt_page = access_q[0].page;
                void'(access_q.pop_front());
              end
            end
            ACT_CFG: begin
              if (idle_now) begin
                nxt_we = 1'b1;
                nxt_wdata = access_q[0].cfg;
                frames_cfg = access_q[0].cfg;
                void'(access_q.pop_front());
              end
            end
            default: begin
              if (idle_now) void'(access_q.pop_front());
            end
          endcase
        end
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
      page_number_i <= nxt_page;
      cfg_wdata_i <= nxt_wdata;
    end
  end

  // Monitor: every strobed result is compared with the oldest prediction.
  frame_outcome_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_results <= 0;
    end else if (done_o) begin
      if (outcome_q.size() == 0) begin
        $error("result with no item outstanding");
        n_errors++;
      end else begin
        want = outcome_q.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          n_errors++;
        end
        if (frame_index_o !== want.frame) begin
          $error("frame_index: expected %0d, got %0d", want.frame, frame_index_o);
          n_errors++;
        end
        if (filled_empty_o !== want.filled_empty) begin
          $error("filled_empty: expected %0d, got %0d", want.filled_empty, filled_empty_o);
          n_errors++;
        end
        if (fault_total_o !== want.fault_total) begin
          $error("fault_total: expected %0d, got %0d", want.fault_total, fault_total_o);
          n_errors++;
        end
      end
      n_results <= n_results + 1;
    end
  end

  int n_items;

  task automatic push_page(input logic [PAGE_BITS_DEF-1:0] page, input int gap);
    access_t a;
    a.act = ACT_PAGE;
    a.page = page;
    a.cfg = '0;
    a.gap = gap;
    access_q.push_back(a);
    n_items++;
  endtask

  task automatic push_ctl(input action_e act, input logic [CFG_W-1:0] cfg);
    access_t a;
    a.act = act;
    a.page = '0;
    a.cfg = cfg;
    a.gap = 0;
    access_q.push_back(a);
  endtask

  initial begin
    int                       phase;
    int                       phase_len;
    int                       idle_mode;
    int                       pool_size;
    int                       gap;
    logic [CFG_W-1:0]         cfg;
    logic [PAGE_BITS_DEF-1:0] pool_base;
    logic [PAGE_BITS_DEF-1:0] page;

    n_accepted = 0;
    n_errors = 0;
    n_items = 0;
    fault_count = '0;
    frames_cfg = FRAMES_IN_USE_RST;
    for (int i = 0; i < FRAMES_DEF; i++) begin
      fr_page[i] = '0;
      fr_valid[i] = 1'b0;
      fr_rank[i] = 0;
    end

    // A zero count acts as one frame, and counts above the table size act as all.
    push_ctl(ACT_CFG, 5'd0);
    push_page(16'h0000, 0);
    push_page(16'hFFFF, 0);
    push_page(16'hFFFF, 0);
    push_ctl(ACT_CFG, 5'd31);
    push_page(16'h0001, 0);
    push_page(16'h0002, 0);
    push_page(16'hFFFF, 0);
    // Shrinking leaves pages in inactive frames, which later yields duplicate
    // matches and tied ranks once the count grows again.
    push_ctl(ACT_CFG, 5'd3);
    push_page(16'h0005, 0);
    push_page(16'h0001, 0);
    push_page(16'h8000, 0);
    push_ctl(ACT_CFG, 5'd1);
    push_page(16'h0001, 0);
    push_page(16'h7FFF, 0);
    push_ctl(ACT_CFG, 5'd16);
    push_page(16'h0001, 0);
    push_page(16'h7FFF, 0);
    push_page(16'h8000, 0);
    push_page(16'h0005, 0);
    push_ctl(ACT_CFG, 5'd17);
    push_page(16'h5555, 0);
    push_page(16'hAAAA, 0);
    push_page(16'h0001, 0);
    push_ctl(ACT_DRAIN, '0);

    phase = 0;
    while (n_items < 1100) begin
      case (phase % 5)
        0: cfg = 5'd16;
        1: cfg = 5'd1;
        2: cfg = ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
        default: cfg = CFG_W'($urandom_range(0, 31));
      endcase
      push_ctl(ACT_CFG, cfg);
      phase_len = $urandom_range(30, 120);
      idle_mode = $urandom_range(0, 2);
      pool_size = eff_frames(cfg) + $urandom_range(0, 4);
      pool_base = PAGE_BITS_DEF'($urandom);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) < 8)
          page = pool_base ^ PAGE_BITS_DEF'($urandom_range(0, pool_size - 1));
        else
          page = PAGE_BITS_DEF'($urandom);
        gap = 0;
        if (n_items < 950) begin
          if (idle_mode == 1 && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
          if (idle_mode == 2 && $urandom_range(0, 1) == 0) gap = $urandom_range(1, 18);
        end
        push_page(page, gap);
        if ($urandom_range(0, 60) == 0) push_ctl(ACT_DRAIN, '0);
      end
      phase++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (access_q.size() != 0) @(negedge clk_i);
    while (n_accepted != n_items || n_accepted != n_results) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_ctrl.sv
rtl/lrupr_dp.sv
rtl/lru_page_replacement.sv
rtl/lru_page_replacement_chk.sv
dv/testbench.sv
